@@ design/bwwu_pkg.sv @@
// Shared constants and the binomial prefix-sum table for the bounded-weight unranker.
package bwwu_pkg;

  localparam int MaxBits = 32;
  localparam int CntW = 6;
  localparam int RankW = 33;
  localparam int WordW = 32;
  localparam int SumW = 34;

  localparam logic [0:0] CfgWordBits = 1'b0;
  localparam logic [0:0] CfgMaxOnes = 1'b1;

  // Sum of C(n, i) for i = 0 .. min(k, n).
  function automatic logic [SumW-1:0] prefix_sum(input logic [CntW-1:0] n,
                                                 input logic [CntW-1:0] k);
    logic [SumW-1:0] c;
    logic [SumW-1:0] acc;
    c = SumW'(1);
    acc = SumW'(1);
    for (int i = 1; i <= MaxBits; i++) begin
      if (i <= int'(n) && i <= int'(k)) begin
        c = SumW'((64'(c) * 64'(int'(n) - i + 1)) / 64'(i));
        acc = acc + c;
      end
    end
    return acc;
  endfunction

endpackage

@@ design/bounded_weight_word_unrank_core.sv @@
// Top level of the bounded-weight word unranker: pipeline of one bit stage per position.
//
// Usage: write word_bits (index 0) and max_ones (index 1) on the cfg channel while
// idle; both reset to 32. Each rank taken on the in channel (valid high, stall low)
// yields one transaction on the out channel: the word of that 1-based rank among
// all word_bits-bit words with at most max_ones ones, and rank_ok. A rank of zero
// or beyond the total count gives word 0 with rank_ok 0.
// The work runs through MaxBits+1 register stages: one entry stage that clamps
// the settings and loads the rank, then one stage per bit position, most
// significant first. The range check is made on the final remainder. out_valid
// rises when the rank reaches the last stage; a new rank may enter each cycle that
// in_stall is low. With out_stall high and the last stage valid, the whole pipeline
// holds and in_stall rises, so nothing is lost or repeated. Reset empties the pipeline.
module bounded_weight_word_unrank_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [bwwu_pkg::RankW-1:0] in_rank,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [bwwu_pkg::WordW-1:0] out_word,
  output logic                       out_rank_ok,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [0:0]                 cfg_index,
  input  logic [5:0]                 cfg_data
);
  import bwwu_pkg::*;

  localparam int Stages = MaxBits + 1;

  logic [CntW-1:0] word_bits_r, max_ones_r;
  logic [CntW-1:0] n_eff, k_eff;
  logic            adv;

  logic              v_r    [Stages];
  logic [SumW-1:0]   rem_r  [Stages];
  logic [CntW-1:0]   ones_r [Stages];
  logic [CntW-1:0]   n_r    [Stages];
  logic [WordW-1:0]  word_r [Stages];
  logic [SumW-1:0]   skip   [1:Stages-1];
  logic              take   [1:Stages-1];

  assign adv = !out_stall || !v_r[Stages-1];
  assign in_stall = !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_bits_r <= CntW'(MaxBits);
      max_ones_r <= CntW'(MaxBits);
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgWordBits: word_bits_r <= cfg_data;
        default:     max_ones_r <= cfg_data;
      endcase
    end
  end

  always_comb begin
    n_eff = (word_bits_r > CntW'(MaxBits)) ? CntW'(MaxBits) : word_bits_r;
    k_eff = (max_ones_r > n_eff) ? n_eff : max_ones_r;
  end

  // Stage s decides position MaxBits - s; skip comes from a constant table per stage.
  always_comb begin
    for (int s = 1; s < Stages; s++) begin
      skip[s] = '0;
      for (int k = 0; k <= MaxBits; k++) begin
        if (ones_r[s-1] == CntW'(k)) skip[s] = prefix_sum(CntW'(MaxBits - s), CntW'(k));
      end
      take[s] = (CntW'(MaxBits - s) < n_r[s-1]) && (ones_r[s-1] != '0)
                && (rem_r[s-1] > skip[s]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < Stages; s++) v_r[s] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
      for (int s = 1; s < Stages; s++) v_r[s] <= v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= SumW'(in_rank);
      ones_r[0] <= k_eff;
      n_r[0] <= n_eff;
      word_r[0] <= '0;
      for (int s = 1; s < Stages; s++) begin
        rem_r[s] <= take[s] ? rem_r[s-1] - skip[s] : rem_r[s-1];
        ones_r[s] <= take[s] ? ones_r[s-1] - CntW'(1) : ones_r[s-1];
        n_r[s] <= n_r[s-1];
        word_r[s] <= word_r[s-1] | (WordW'(take[s]) << (MaxBits - s));
      end
    end
  end

  // A rank inside the count always leaves a remainder of exactly one.
  assign out_valid = v_r[Stages-1];
  assign out_rank_ok = (rem_r[Stages-1] == SumW'(1));
  assign out_word = out_rank_ok ? word_r[Stages-1] : '0;

endmodule
